// ===== rtl/core/sirs_pkg.sv =====
// Package for the ordered-sequence core: widths, command and status codes,
// controller states and the control struct for the write-back datapath.
// No dependencies.
package sirs_pkg;

   localparam int DEFAULT_CAPACITY = 1024;
   localparam int DATA_W           = 64;
   localparam int POS_W            = 11;
   localparam int LEN_W            = 11;
   localparam int CMD_W            = 2;
   localparam int STATUS_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_SUM    = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DRAIN,
      FSM_INS_NEW,
      FSM_FINISH
   } fsm_type;

   // control for the datapath behind the RAM read port
   typedef struct packed {
      logic acc_clear;   // start a new sum
      logic acc_en;      // add the read word to the sum
      logic wb_copy;     // write back the read word unchanged (insert shift)
   } alu_ctrl_type;

endpackage

// ===== rtl/core/sequence_insert_range_add_sum_core.sv =====
// Channel | direction | handshake          | word
// req     | in        | req_valid/req_ready | command, left_pos, right_pos, value
// rsp     | out       | rsp_valid/rsp_ready | status, range_sum, length
//
// One word at a time. Insert at position p shifts the elements from the tail down to p
// up by one, then writes the new value; range add and range sum walk left to right.
// The single RAM read port walks one element per cycle; rejected words skip the walk.
// Reset empties the sequence at once; RAM contents are left as they are.
// A result waiting on rsp_ready holds in the output register; the next word
// is taken meanwhile and its work runs up to the point of handing over a result.
// Top level of the ordered-sequence core. Depends on sirs_pkg, sirs_ram, sirs_alu.
module sequence_insert_range_add_sum_core
   import sirs_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [POS_W-1:0]           req_left_pos,
   input  logic [POS_W-1:0]           req_right_pos,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0]   rsp_range_sum,
   output logic [LEN_W-1:0]           rsp_length
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   fsm_type           state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     wb_addr_ff, wb_addr_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   logic              req_fire;
   cmd_type           req_cmd;
   logic [CMPW-1:0]   l_x, r_x, cnt_x;
   logic              ins_pos_ok, range_ok, is_full;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;
   logic [DATA_W-1:0] alu_wdata;
   logic [DATA_W-1:0] acc;
   alu_ctrl_type      alu_ctrl;

   assign req_cmd  = cmd_type'(req_command);
   assign req_fire = req_valid && req_ready;
   assign l_x      = CMPW'(req_left_pos);
   assign r_x      = CMPW'(req_right_pos);
   assign cnt_x    = CMPW'(count_ff);

   assign ins_pos_ok = (l_x >= CMPW'(1)) && (l_x <= cnt_x + CMPW'(1));
   assign range_ok   = (l_x >= CMPW'(1)) && (l_x <= r_x) && (r_x <= cnt_x);
   assign is_full    = (cnt_x >= CMPW'(CAPACITY));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      pos_ff        <= pos_in;
      wb_addr_ff    <= wb_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_len_ff    <= rsp_len_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      pos_in        = pos_ff;
      wb_addr_in    = wb_addr_ff;
      pend_in       = 1'b0;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_len_in    = rsp_len_ff;
      req_ready     = 1'b0;
      alu_ctrl      = '0;
      ram_we        = 1'b0;
      ram_waddr     = wb_addr_ff;
      ram_wdata     = alu_wdata;

      // write back, or add to the sum, the word read in the previous cycle
      if (pend_ff) begin
         ram_we         = (cmd_ff != CMD_SUM);
         alu_ctrl.acc_en = (cmd_ff == CMD_SUM);
      end
      alu_ctrl.wb_copy = (cmd_ff == CMD_INSERT);

      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd_in             = req_cmd;
               value_in           = req_value;
               status_in          = STATUS_OK;
               alu_ctrl.acc_clear = 1'b1;
               state_in           = FSM_FINISH;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     pos_in = AW'(l_x - CMPW'(1));
                     ptr_in = AW'(cnt_x - CMPW'(1));
                     end_in = AW'(l_x - CMPW'(1));
                     if (!ins_pos_ok) begin
                        status_in = STATUS_RANGE;
                     end else if (is_full) begin
                        status_in = STATUS_FULL;
                     end else if (l_x - CMPW'(1) == cnt_x) begin
                        state_in = FSM_INS_NEW;
                     end else begin
                        state_in = FSM_SCAN;
                     end
                  end
                  CMD_ADD, CMD_SUM: begin
                     ptr_in = AW'(l_x - CMPW'(1));
                     end_in = AW'(r_x - CMPW'(1));
                     if (range_ok) begin
                        state_in = FSM_SCAN;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  default: begin
                     status_in = STATUS_RANGE;
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            pend_in    = 1'b1;
            wb_addr_in = (cmd_ff == CMD_INSERT) ? ptr_ff + AW'(1) : ptr_ff;
            if (ptr_ff == end_ff) begin
               state_in = FSM_DRAIN;
            end else begin
               // insert walks down from the tail, ranges walk up
               ptr_in = (cmd_ff == CMD_INSERT) ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            end
         end
         FSM_DRAIN: begin
            state_in = (cmd_ff == CMD_INSERT) ? FSM_INS_NEW : FSM_FINISH;
         end
         FSM_INS_NEW: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = value_ff;
            count_in  = count_ff + CW'(1);
            state_in  = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_sum_in    = (status_ff == STATUS_OK && cmd_ff == CMD_SUM) ? acc : '0;
               rsp_len_in    = LEN_W'(count_ff);
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   sirs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   sirs_alu u_alu (
      .clock   (clock),
      .ctrl    (alu_ctrl),
      .rd_data (ram_rdata),
      .operand (value_ff),
      .wr_data (alu_wdata),
      .acc     (acc)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_length    = rsp_len_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= CMPW'(CAPACITY))
      else $error("element count beyond capacity");

   a_pend_after_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff) == FSM_SCAN)
      else $error("write-back pending without a preceding read");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_INS_NEW |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the sequence by one");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN && ram_we) |-> ram_waddr != ptr_ff)
      else $error("read and write-back hit the same entry");

   a_err_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_range_sum == '0)
      else $error("rejected word carries a non-zero sum");
`endif

endmodule

// ===== rtl/core/sirs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sirs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sirs_alu.sv =====
// Write-back datapath behind the RAM read port: add for range add, plain copy
// for the insert shift, and the running range sum. Depends on sirs_pkg.
module sirs_alu
   import sirs_pkg::*;
(
   input  logic              clock,
   input  alu_ctrl_type      ctrl,
   input  logic [DATA_W-1:0] rd_data,
   input  logic [DATA_W-1:0] operand,
   output logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] acc
);

   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;

   assign wr_data = ctrl.wb_copy ? rd_data : rd_data + operand;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + rd_data;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
